// ----- sv/drpc_pkg.sv -----
package drpc_pkg;

	// event codes carried in func
	typedef enum logic [3:0] {
		FN_REFR_START   = 4'd0,
		FN_REFR_READY   = 4'd1,
		FN_RENDER_START = 4'd2,
		FN_RENDER_READY = 4'd3,
		FN_FLUSH        = 4'd4,
		FN_WAIT_START   = 4'd5,
		FN_WAIT_FINISH  = 4'd6,
		FN_AREA         = 4'd7,
		FN_SNAPSHOT     = 4'd8
	} func_t;

	localparam int STAT_COUNT = 14;
	localparam int STAT_IDX_W = $clog2(STAT_COUNT);

	// order of statistics in a snapshot run
	typedef enum logic [STAT_IDX_W-1:0] {
		ST_WINDOW      = 4'd0,
		ST_REFR_COUNT  = 4'd1,
		ST_DRAWN_COUNT = 4'd2,
		ST_FLUSH_COUNT = 4'd3,
		ST_OVERRUN     = 4'd4,
		ST_REFR_SUM    = 4'd5,
		ST_REFR_MAX    = 4'd6,
		ST_RENDER_SUM  = 4'd7,
		ST_RENDER_MAX  = 4'd8,
		ST_WAIT_SUM    = 4'd9,
		ST_WAIT_MAX    = 4'd10,
		ST_AREA_SUM    = 4'd11,
		ST_AREA_COUNT  = 4'd12,
		ST_AREA_MAX    = 4'd13
	} stat_t;

	localparam int FUNC_W        = 4;
	localparam int TS_W          = 63;
	localparam int COORD_FIELD_W = 16;
	localparam int STAT_W        = 64;
	localparam int AREA_COORD_BITS = 16;

	localparam int PERIOD_W       = 16;
	localparam int PERIOD_US_W    = 26;
	localparam int US_PER_MS      = 1000;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd33;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_PERIOD = 1'b0;

	typedef logic [STAT_COUNT-1:0][STAT_W-1:0] stat_vec_t;

endpackage

// ----- sv/drpc_event_if.sv -----
interface drpc_event_if;
	import drpc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic [TS_W-1:0]          timestamp_us;
	logic [COORD_FIELD_W-1:0] area_width;
	logic [COORD_FIELD_W-1:0] area_height;

	modport source (output valid, func, timestamp_us, area_width, area_height, input ready);
	modport sink (input valid, func, timestamp_us, area_width, area_height, output ready);

endinterface

// ----- sv/drpc_stat_if.sv -----
interface drpc_stat_if;
	import drpc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [STAT_IDX_W-1:0] stat_index;
	logic [STAT_W-1:0]     stat_value;
	logic                  last;

	modport source (output valid, stat_index, stat_value, last, input ready);
	modport sink (input valid, stat_index, stat_value, last, output ready);

endinterface

// ----- sv/display_refresh_perf_counters_unit.sv -----
// channel  dir  modport          payload
// evt      in   drpc_event_if    func, timestamp_us, area_width, area_height
// stat     out  drpc_stat_if     stat_index, stat_value, last
// apb      in   psel..pready     refresh period (ms) at byte address 0
//
// events pass the event stage register; one beat a cycle unless a snapshot waits.
// a snapshot yields fourteen beats from the stat shift line, one per ready cycle.
// the event stage holds a snapshot only while the previous run is still draining,
// so the stat streamer sets the rate for back-to-back snapshots.
// arst_n clears all counters, sums, maxima, times and the stage valids;
// the refresh period comes out of reset at 33 ms.
module display_refresh_perf_counters_unit
	import drpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	drpc_event_if.sink            evt,
	drpc_stat_if.source           stat,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	// ---------------- configuration ----------------
	logic [PERIOD_W-1:0]    refr_period_q;
	logic [PERIOD_US_W-1:0] period_us_q;   // period in us, kept beside the ms value
	logic                   cfg_wr;
	logic [PERIOD_W-1:0]    wr_period;

	assign pready    = 1'b1;
	assign wr_period = pwdata[PERIOD_W-1:0];
	assign cfg_wr    = psel && penable && pwrite && (paddr[2] == REG_PERIOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refr_period_q <= PERIOD_RESET;
			period_us_q   <= PERIOD_US_W'(32'(PERIOD_RESET) * US_PER_MS);
		end else if (cfg_wr && (wr_period != '0)) begin
			// a zero period is dropped
			refr_period_q <= wr_period;
			period_us_q   <= PERIOD_US_W'(32'(wr_period) * US_PER_MS);
		end
	end

	assign prdata = (paddr[2] == REG_PERIOD) ? APB_DATA_W'(refr_period_q) : '0;

	// ---------------- input register ----------------
	logic                   valid_s1;
	logic [FUNC_W-1:0]      func_s1;
	logic [TS_W-1:0]        now_s1;
	logic [31:0]            px_s1;
	logic                   adv_s1;
	logic [AREA_COORD_BITS-1:0] coord_w;
	logic [AREA_COORD_BITS-1:0] coord_h;
	logic                   snap_load;
	logic                   snap_can_load;

	// product is formed on the way into the stage register
	assign coord_w = AREA_COORD_BITS'(evt.area_width);
	assign coord_h = AREA_COORD_BITS'(evt.area_height);

	// a snapshot waits only while the last run is still on the port
	assign adv_s1    = valid_s1 && ((func_s1 != FN_SNAPSHOT) || snap_can_load);
	assign evt.ready = !valid_s1 || adv_s1;
	assign snap_load = adv_s1 && (func_s1 == FN_SNAPSHOT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.valid && evt.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			func_s1 <= evt.func;
			now_s1  <= evt.timestamp_us;
			px_s1   <= 32'(coord_w) * 32'(coord_h);
		end
	end

	// ---------------- per-cycle and window state ----------------
	// only the low 32 bits of start times matter: spans are taken mod 2^32
	logic [31:0]   refr_start_q, render_start_q, wait_start_q;
	logic [31:0]   cyc_render_q, cyc_wait_q;
	logic          cyc_drew_q;
	logic [31:0]   refr_count_q, drawn_count_q, flush_count_q, overrun_q;
	logic [63:0]   refr_sum_q, render_sum_q, wait_sum_q;
	logic [31:0]   refr_max_q, render_max_q, wait_max_q;
	logic [63:0]   area_sum_q;
	logic [31:0]   area_count_q, area_max_q;
	logic [TS_W-1:0] win_start_q;

	logic [31:0]   refr_span, render_span, wait_span;
	logic [TS_W-1:0] win_len;
	stat_vec_t     snap_vals;

	assign refr_span   = now_s1[31:0] - refr_start_q;
	assign render_span = now_s1[31:0] - render_start_q;
	assign wait_span   = now_s1[31:0] - wait_start_q;
	// non-positive window length reads as one
	assign win_len     = (now_s1 > win_start_q) ? (now_s1 - win_start_q) : TS_W'(1);

	always_comb begin
		snap_vals                 = '0;
		snap_vals[ST_WINDOW]      = STAT_W'(win_len);
		snap_vals[ST_REFR_COUNT]  = STAT_W'(refr_count_q);
		snap_vals[ST_DRAWN_COUNT] = STAT_W'(drawn_count_q);
		snap_vals[ST_FLUSH_COUNT] = STAT_W'(flush_count_q);
		snap_vals[ST_OVERRUN]     = STAT_W'(overrun_q);
		snap_vals[ST_REFR_SUM]    = refr_sum_q;
		snap_vals[ST_REFR_MAX]    = STAT_W'(refr_max_q);
		snap_vals[ST_RENDER_SUM]  = render_sum_q;
		snap_vals[ST_RENDER_MAX]  = STAT_W'(render_max_q);
		snap_vals[ST_WAIT_SUM]    = wait_sum_q;
		snap_vals[ST_WAIT_MAX]    = STAT_W'(wait_max_q);
		snap_vals[ST_AREA_SUM]    = area_sum_q;
		snap_vals[ST_AREA_COUNT]  = STAT_W'(area_count_q);
		snap_vals[ST_AREA_MAX]    = STAT_W'(area_max_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refr_start_q   <= '0;
			render_start_q <= '0;
			wait_start_q   <= '0;
			cyc_render_q   <= '0;
			cyc_wait_q     <= '0;
			cyc_drew_q     <= 1'b0;
			refr_count_q   <= '0;
			drawn_count_q  <= '0;
			flush_count_q  <= '0;
			overrun_q      <= '0;
			refr_sum_q     <= '0;
			render_sum_q   <= '0;
			wait_sum_q     <= '0;
			refr_max_q     <= '0;
			render_max_q   <= '0;
			wait_max_q     <= '0;
			area_sum_q     <= '0;
			area_count_q   <= '0;
			area_max_q     <= '0;
			win_start_q    <= '0;
		end else if (adv_s1) begin
			case (func_s1)
				FN_REFR_START: begin
					refr_start_q <= now_s1[31:0];
					cyc_render_q <= '0;
					cyc_wait_q   <= '0;
					cyc_drew_q   <= 1'b0;
				end
				FN_REFR_READY: begin
					refr_count_q <= refr_count_q + 1'b1;
					// only cycles that drew feed the timing stats
					if (cyc_drew_q) begin
						drawn_count_q <= drawn_count_q + 1'b1;
						refr_sum_q    <= refr_sum_q + 64'(refr_span);
						render_sum_q  <= render_sum_q + 64'(cyc_render_q);
						wait_sum_q    <= wait_sum_q + 64'(cyc_wait_q);
						if (refr_span > refr_max_q) begin
							refr_max_q <= refr_span;
						end
						if (cyc_render_q > render_max_q) begin
							render_max_q <= cyc_render_q;
						end
						if (cyc_wait_q > wait_max_q) begin
							wait_max_q <= cyc_wait_q;
						end
						if (refr_span > 32'(period_us_q)) begin
							overrun_q <= overrun_q + 1'b1;
						end
					end
				end
				FN_RENDER_START: begin
					render_start_q <= now_s1[31:0];
					cyc_drew_q     <= 1'b1;
				end
				FN_RENDER_READY: begin
					cyc_render_q <= cyc_render_q + render_span;
				end
				FN_FLUSH: begin
					flush_count_q <= flush_count_q + 1'b1;
				end
				FN_WAIT_START: begin
					wait_start_q <= now_s1[31:0];
				end
				FN_WAIT_FINISH: begin
					cyc_wait_q <= cyc_wait_q + wait_span;
				end
				FN_AREA: begin
					area_sum_q   <= area_sum_q + 64'(px_s1);
					area_count_q <= area_count_q + 1'b1;
					if (px_s1 > area_max_q) begin
						area_max_q <= px_s1;
					end
				end
				FN_SNAPSHOT: begin
					// values already handed to the streamer; open a new window
					refr_count_q  <= '0;
					drawn_count_q <= '0;
					flush_count_q <= '0;
					overrun_q     <= '0;
					refr_sum_q    <= '0;
					render_sum_q  <= '0;
					wait_sum_q    <= '0;
					refr_max_q    <= '0;
					render_max_q  <= '0;
					wait_max_q    <= '0;
					area_sum_q    <= '0;
					area_count_q  <= '0;
					area_max_q    <= '0;
					win_start_q   <= now_s1;
				end
				default: begin
					// unknown codes leave everything alone
				end
			endcase
		end
	end

	// ---------------- result streamer ----------------
	drpc_stat_stream u_stream (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (snap_load),
		.vals     (snap_vals),
		.can_load (snap_can_load),
		.stat     (stat)
	);

`ifndef SYNTHESIS
	// the event stage only ever waits on a snapshot
	a_stall_only_snapshot: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |-> (func_s1 == FN_SNAPSHOT))
		else $error("event stage stalled on a non-snapshot event");

	// a snapshot run starts at index zero in the next cycle
	a_snapshot_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		snap_load |=> (stat.valid && (stat.stat_index == ST_WINDOW)))
		else $error("snapshot did not start a stat run");

	// the window is empty right after a snapshot
	a_snapshot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		snap_load |=> ((refr_count_q == '0) && (area_count_q == '0) && (area_sum_q == '0)))
		else $error("window not cleared by snapshot");

	// us period tracks the ms register
	a_period_match: assert property (@(posedge clk) disable iff (!arst_n)
		(refr_period_q != '0) && (32'(period_us_q) == 32'(refr_period_q) * 32'(US_PER_MS)))
		else $error("period registers out of step");
`endif

endmodule

// ----- sv/drpc_stat_stream.sv -----
module drpc_stat_stream
	import drpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  stat_vec_t   vals,
	output logic        can_load,
	drpc_stat_if.source stat
);

	localparam logic [STAT_IDX_W-1:0] LAST_IDX = STAT_IDX_W'(STAT_COUNT - 1);

	stat_vec_t             sbuf_q;
	logic [STAT_IDX_W-1:0] idx_q;
	logic                  valid_q;
	logic                  take;
	logic                  at_last;

	assign at_last  = (idx_q == LAST_IDX);
	assign take     = valid_q && stat.ready;
	assign can_load = !valid_q || (stat.ready && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (take) begin
			if (at_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// head of the shift line is the beat on the port
	always_ff @(posedge clk) begin
		if (load) begin
			sbuf_q <= vals;
		end else if (take) begin
			for (int k = 0; k < STAT_COUNT - 1; k++) begin
				sbuf_q[k] <= sbuf_q[k+1];
			end
		end
	end

	assign stat.valid      = valid_q;
	assign stat.stat_index = idx_q;
	assign stat.stat_value = sbuf_q[0];
	assign stat.last       = at_last;

endmodule

// ----- bench/drpc_stat_checker.sv -----
`timescale 1ns / 1ps

module drpc_stat_checker
	import drpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	drpc_event_if                 evt,
	drpc_stat_if                  stat,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output int unsigned           errors,
	output int unsigned           pending
);

	typedef struct {
		stat_t             idx;
		logic [STAT_W-1:0] value;
		logic              last;
	} stat_beat_t;

	stat_beat_t expected_stats[$];

	logic [PERIOD_W-1:0] refr_period;
	logic [63:0] refr_t0, render_t0, wait_t0, window_t0;
	logic [31:0] cyc_render_us, cyc_wait_us;
	logic        cyc_drew;
	logic [31:0] n_refr, n_drawn, n_flush, n_overrun, n_area;
	logic [63:0] refr_sum, render_sum, wait_sum, px_sum;
	logic [31:0] refr_peak, render_peak, wait_peak, px_peak;

	function automatic logic [31:0] elapsed32(input logic [63:0] now, input logic [63:0] since);
		logic [63:0] d;
		d = now - since;
		return d[31:0];
	endfunction

	task automatic clear_window(input logic [63:0] now);
		n_refr = '0;
		n_drawn = '0;
		n_flush = '0;
		n_overrun = '0;
		n_area = '0;
		refr_sum = '0;
		render_sum = '0;
		wait_sum = '0;
		px_sum = '0;
		refr_peak = '0;
		render_peak = '0;
		wait_peak = '0;
		px_peak = '0;
		window_t0 = now;
	endtask

	task automatic apply_event(input logic [FUNC_W-1:0] f, input logic [63:0] now,
			input logic [COORD_FIELD_W-1:0] w, input logic [COORD_FIELD_W-1:0] h);
		logic [31:0]       total;
		logic [31:0]       px;
		logic [31:0]       limit_us;
		logic [63:0]       window_us;
		logic [STAT_W-1:0] snap [STAT_COUNT];
		int                k;
		total = elapsed32(now, refr_t0);
		px = 32'(w[AREA_COORD_BITS-1:0]) * 32'(h[AREA_COORD_BITS-1:0]);
		limit_us = 32'(refr_period) * 32'(US_PER_MS);
		case (f)
			FN_REFR_START: begin
				refr_t0 = now;
				cyc_render_us = '0;
				cyc_wait_us = '0;
				cyc_drew = 1'b0;
			end
			FN_REFR_READY: begin
				n_refr++;
				if (cyc_drew) begin
					n_drawn++;
					refr_sum += 64'(total);
					render_sum += 64'(cyc_render_us);
					wait_sum += 64'(cyc_wait_us);
					if (total > refr_peak) refr_peak = total;
					if (cyc_render_us > render_peak) render_peak = cyc_render_us;
					if (cyc_wait_us > wait_peak) wait_peak = cyc_wait_us;
					if (total > limit_us) n_overrun++;
				end
			end
			FN_RENDER_START: begin
				render_t0 = now;
				cyc_drew = 1'b1;
			end
			FN_RENDER_READY: cyc_render_us += elapsed32(now, render_t0);
			FN_FLUSH: n_flush++;
			FN_WAIT_START: wait_t0 = now;
			FN_WAIT_FINISH: cyc_wait_us += elapsed32(now, wait_t0);
			FN_AREA: begin
				px_sum += 64'(px);
				n_area++;
				if (px > px_peak) px_peak = px;
			end
			FN_SNAPSHOT: begin
				window_us = (now > window_t0) ? now - window_t0 : 64'd1;
				snap = '{window_us, 64'(n_refr), 64'(n_drawn), 64'(n_flush), 64'(n_overrun),
					refr_sum, 64'(refr_peak), render_sum, 64'(render_peak),
					wait_sum, 64'(wait_peak), px_sum, 64'(n_area), 64'(px_peak)};
				for (k = 0; k < STAT_COUNT; k++)
					expected_stats.push_back('{stat_t'(k), snap[k], k == STAT_COUNT - 1});
				clear_window(now);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin : track
		stat_beat_t want;
		if (!arst_n) begin
			refr_period = PERIOD_RESET;
			refr_t0 = '0;
			render_t0 = '0;
			wait_t0 = '0;
			cyc_render_us = '0;
			cyc_wait_us = '0;
			cyc_drew = 1'b0;
			clear_window('0);
			expected_stats.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (stat.valid && stat.ready) begin
				if (expected_stats.size() == 0) begin
					errors++;
					$display("%0t: unexpected stat beat, expected none, actual index %0d value %0h",
						$time, stat.stat_index, stat.stat_value);
				end else begin
					want = expected_stats.pop_front();
					if (stat.stat_index !== want.idx) begin
						errors++;
						$display("%0t: stat_index expected %0d, actual %0d",
							$time, want.idx, stat.stat_index);
					end
					if (stat.stat_value !== want.value) begin
						errors++;
						$display("%0t: stat_value (index %0d) expected %0h, actual %0h",
							$time, want.idx, want.value, stat.stat_value);
					end
					if (stat.last !== want.last) begin
						errors++;
						$display("%0t: last (index %0d) expected %0b, actual %0b",
							$time, want.idx, want.last, stat.last);
					end
				end
			end
			if (psel && penable && pwrite && pready && (paddr >> 2) == REG_PERIOD)
				if (pwdata[PERIOD_W-1:0] != '0) refr_period = pwdata[PERIOD_W-1:0];
			if (evt.valid && evt.ready)
				apply_event(evt.func, {1'b0, evt.timestamp_us}, evt.area_width, evt.area_height);
			pending <= expected_stats.size();
		end
	end

endmodule

// ----- bench/display_refresh_perf_counters_unit_test.sv -----
`timescale 1ns / 1ps

module display_refresh_perf_counters_unit_test;
	import drpc_pkg::*;

	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 8;     // event stage plus start of a stat run
	localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
	localparam int STALL_LIMIT   = 3000;  // cycles without any beat or APB access before giving up

	// func codes the block does not know
	localparam logic [FUNC_W-1:0] FN_UNKNOWN_LO = 4'd9;
	localparam logic [FUNC_W-1:0] FN_UNKNOWN_HI = 4'd15;

	// byte addresses: the period register and an unmapped word
	localparam logic [APB_ADDR_W-1:0] ADDR_PERIOD   = APB_ADDR_W'(4 * REG_PERIOD);
	localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = APB_ADDR_W'(4);

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel, penable, pwrite, pready;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata, prdata;

	drpc_event_if evt_ch();
	drpc_stat_if  stat_ch();

	int unsigned errors, pending;
	int unsigned tx_idle_pct, rx_idle_pct;
	int unsigned hold_req, hold_ack, hold_left;
	int unsigned beats_sent;
	logic [TS_W-1:0] now_us;

	always #4 clk = ~clk;

	display_refresh_perf_counters_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.evt     (evt_ch),
		.stat    (stat_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	drpc_stat_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.evt     (evt_ch),
		.stat    (stat_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.errors  (errors),
		.pending (pending)
	);

	// stat receiver: random back-pressure, or a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			stat_ch.ready <= 1'b0;
			hold_left <= 0;
			hold_ack <= 0;
		end else if (hold_left != 0) begin
			stat_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			stat_ch.ready <= 1'b0;
		end else begin
			stat_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// watchdog: ends the run when nothing moves for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((evt_ch.valid && evt_ch.ready) || (stat_ch.valid && stat_ch.ready)
					|| (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILED: results differ");
		$finish;
	end

	// dimension with the extremes weighted up
	function automatic logic [COORD_FIELD_W-1:0] rand_dim();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return COORD_FIELD_W'($urandom());
		endcase
	endfunction

	function automatic logic [TS_W-1:0] rand_ts();
		return TS_W'({$urandom(), $urandom()});
	endfunction

	// offer one event beat and hold it until the block takes it
	task automatic put_event(input logic [FUNC_W-1:0] f, input logic [TS_W-1:0] ts,
			input logic [COORD_FIELD_W-1:0] w = '0, input logic [COORD_FIELD_W-1:0] h = '0);
		while ($urandom_range(99) < tx_idle_pct) begin
			evt_ch.valid <= 1'b0;
			@(posedge clk);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.func <= f;
		evt_ch.timestamp_us <= ts;
		evt_ch.area_width <= w;
		evt_ch.area_height <= h;
		@(posedge clk);
		while (!evt_ch.ready) @(posedge clk);
		beats_sent++;
	endtask

	// advance time by up to span us, then send the event
	task automatic tick(input logic [FUNC_W-1:0] f, input int unsigned span);
		now_us = now_us + TS_W'($urandom_range(span));
		put_event(f, now_us, rand_dim(), rand_dim());
	endtask

	// pause the sender until every stat beat is in and the block has gone quiet
	task automatic wait_drained();
		evt_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// one refresh cycle, mostly well formed; sometimes the start is missing
	// or time jumps anywhere (backwards included)
	task automatic run_refresh_cycle();
		int unsigned span;
		case ($urandom_range(3))
			0: span = 300;
			1: span = 3000;
			2: span = 30000;
			default: span = 90000;
		endcase
		if ($urandom_range(9) != 0) tick(FN_REFR_START, span);
		repeat ($urandom_range(2)) begin
			tick(FN_RENDER_START, span);
			tick(FN_RENDER_READY, span);
		end
		if ($urandom_range(1)) tick(FN_FLUSH, span);
		repeat ($urandom_range(2)) begin
			tick(FN_WAIT_START, span);
			tick(FN_WAIT_FINISH, span);
		end
		repeat ($urandom_range(2)) tick(FN_AREA, span);
		if ($urandom_range(19) == 0) now_us = rand_ts();
		tick(FN_REFR_READY, span);
	endtask

	task automatic run_random(input int unsigned target);
		int unsigned pick;
		while (beats_sent < target) begin
			pick = $urandom_range(9);
			if (pick < 6)
				run_refresh_cycle();
			else if (pick < 8)
				tick(FN_SNAPSHOT, 100000);
			else if (pick == 8)
				put_event(FUNC_W'($urandom()), rand_ts(), rand_dim(), rand_dim());
			else
				tick(FUNC_W'($urandom()), 5000);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		evt_ch.valid = 1'b0;
		evt_ch.func = '0;
		evt_ch.timestamp_us = '0;
		evt_ch.area_width = '0;
		evt_ch.area_height = '0;
		hold_req = 0;
		beats_sent = 0;
		now_us = '0;
		tx_idle_pct = 35;
		rx_idle_pct = 72;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty window at time zero reports a length of 1
		put_event(FN_SNAPSHOT, '0);
		put_event(FN_REFR_START, 63'd1000);
		put_event(FN_RENDER_START, 63'd2000);
		// render ends before it started, so the duration wraps
		put_event(FN_RENDER_READY, 63'd1500);
		put_event(FN_RENDER_START, 63'd3000);
		put_event(FN_RENDER_READY, 63'd9000);
		put_event(FN_WAIT_START, 63'd10000);
		put_event(FN_WAIT_FINISH, 63'd45000);
		put_event(FN_FLUSH, 63'd45500);
		put_event(FN_AREA, 63'd46000, '1, '1);
		put_event(FN_AREA, 63'd46100, '0, '0);
		put_event(FN_AREA, 63'd46200, 16'd1, '1);
		// drawn, 49 ms against a 33 ms period: overrun
		put_event(FN_REFR_READY, 63'd50000);
		put_event(FN_REFR_START, 63'd50000);
		put_event(FN_RENDER_START, 63'd51000);
		put_event(FN_RENDER_READY, 63'd52000);
		// exactly one period is not an overrun
		put_event(FN_REFR_READY, 63'd83000);
		put_event(FN_REFR_START, '1);
		// nothing drawn, and the refresh time wraps
		put_event(FN_REFR_READY, 63'd5);
		put_event(FN_UNKNOWN_LO, 63'd7, '1, '1);
		put_event(FN_UNKNOWN_HI, '1, '1, '1);
		put_event(FN_SNAPSHOT, '1);
		// snapshot before, then at, the window start: length 1
		put_event(FN_SNAPSHOT, 63'd5);
		put_event(FN_SNAPSHOT, 63'd5);
		wait_drained();

		// shortest period: nearly every drawn cycle overruns
		apb_write(ADDR_PERIOD, 32'd1);
		now_us = rand_ts();
		run_random(90);
		wait_drained();

		// sender now idles more than the receiver
		tx_idle_pct = 72;
		rx_idle_pct <= 35;
		// zero period and an unmapped word are both ignored
		apb_write(ADDR_PERIOD, '0);
		apb_write(ADDR_UNMAPPED, $urandom());
		// longest period, with junk in the upper bits
		apb_write(ADDR_PERIOD, {16'($urandom()), 16'hFFFF});
		run_random(150);
		wait_drained();

		// no idling on either side; period around the usual frame time
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		apb_write(ADDR_PERIOD, $urandom_range(20, 45));
		// receiver holds off while snapshots keep coming, so the input stalls
		hold_req <= hold_req + 1;
		repeat (6) begin
			tick(FN_SNAPSHOT, 2000);
			tick(FN_AREA, 2000);
			tick(FN_FLUSH, 2000);
		end
		wait_drained();
		run_random(215);
		wait_drained();

		if (errors == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- display_refresh_perf_counters_unit.f -----
sv/drpc_pkg.sv
sv/drpc_event_if.sv
sv/drpc_stat_if.sv
sv/drpc_stat_stream.sv
sv/display_refresh_perf_counters_unit.sv
bench/drpc_stat_checker.sv
bench/display_refresh_perf_counters_unit_test.sv
